### rtl/tqqa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqqa_pkg - shared types and constants of the two-queue quota arbiter
// Transfer structs, status / request / mode codes, register indexes and
// divider widths.
// ----------------------------------------------------------------------------
package tqqa_pkg;

  typedef struct packed {
    logic        req_type;
    logic        side;
    logic [15:0] car_id;
    logic [1:0]  car_type;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        granted_side;
    logic [15:0] granted_id;
    logic [1:0]  granted_type;
    logic [15:0] crossing_time;
  } out_item_t;

  // one queue slot: type over id
  typedef struct packed {
    logic [1:0]  car_type;
    logic [15:0] car_id;
  } qentry_t;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_SERVE   = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_GRANTED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [1:0] MODE_QUOTA  = 2'd0;
  localparam logic [1:0] MODE_SIGN   = 2'd1;
  localparam logic [1:0] MODE_RANDOM = 2'd2;

  localparam logic [1:0] CAR_SPORT     = 2'd1;
  localparam logic [1:0] CAR_EMERGENCY = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTA         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STREET_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAR_SPEED     = 2'd3;

  localparam logic [1:0]  FLOW_MODE_RST = 2'd0;
  localparam logic [7:0]  QUOTA_RST     = 8'd3;
  localparam logic [15:0] LENGTH_RST    = 16'd100;
  localparam logic [15:0] SPEED_RST     = 16'd10;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  // dividend up to 7*length, divisor up to 10*speed
  localparam int DIVIDEND_W = 19;
  localparam int DIVISOR_W  = 20;

endpackage : tqqa_pkg
`default_nettype wire

### rtl/two_queue_quota_arbiter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_queue_quota_arbiter_unit - two-queue lane arbiter, top level
// Left/right car queues in RAM, quota / sign / random side policy and a
// shared iterative divider for the crossing time of the granted car.
// ----------------------------------------------------------------------------
//
//  channel  ports                            direction  handshake
//  -------  -------------------------------  ---------  ---------------------
//  input    start, busy, in_data             in         start & !busy
//  result   out_valid, out_data              out        one-cycle strobe
//  config   cfg_we, cfg_index, cfg_wdata     in         cfg_we, no wait
//
//  Enqueue transfers and serve transfers that grant nothing answer in the
//  cycle after acceptance; busy stays low, so a new item may follow at once.
//  A granted serve reads the queue RAM (S_READ), then runs the 19-step
//  divider (S_DIV), one quotient bit per cycle; busy stays high until the
//  result is out on out_valid.
//  Synchronous active-low reset clears queue pointers, policy state and the
//  LFSR; queue RAM contents are not cleared. The receiver cannot stall.
//
module two_queue_quota_arbiter_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire tqqa_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  output tqqa_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [tqqa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tqqa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tqqa_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);      // slot address
  localparam int CW = $clog2(QUEUE_DEPTH + 1);  // fill count
  localparam int PW = CW + 1;                   // head + count sum
  localparam int QW = $bits(qentry_t);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV} state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r    [2];
  logic [CW-1:0]   cnt_nxt  [2];
  logic [AW-1:0]   head_r   [2];
  logic [AW-1:0]   head_nxt [2];
  logic [7:0]      passed_r [2];
  logic [7:0]      passed_nxt [2];
  logic            flow_dir_r, flow_dir_nxt;
  logic            sign_dir_r, sign_dir_nxt;
  logic [15:0]     lfsr_r, lfsr_nxt;
  logic            gnt_side_r, gnt_side_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic [1:0]      mode_r, mode_nxt;
  logic [7:0]      quota_r, quota_nxt;
  logic [15:0]     length_r, length_nxt;
  logic [15:0]     speed_r, speed_nxt;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_comb begin
    mode_nxt   = mode_r;
    quota_nxt  = quota_r;
    length_nxt = length_r;
    speed_nxt  = speed_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FLOW_MODE:     mode_nxt   = cfg_wdata[1:0];
        REG_QUOTA:         quota_nxt  = cfg_wdata[7:0];
        REG_STREET_LENGTH: length_nxt = cfg_wdata;
        REG_CAR_SPEED:     speed_nxt  = cfg_wdata;
        default:           mode_nxt   = mode_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Queue RAMs, one per side
  // --------------------------------------------------------------------------
  logic          ram_we [2];
  logic          ram_re [2];
  logic [AW-1:0] ram_waddr;
  qentry_t       ram_wdata;
  qentry_t       ram_rdata [2];

  for (genvar g = 0; g < 2; g++) begin : g_queue
    tqqa_ram #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re[g]),
      .raddr (head_r[g]),
      .rdata (ram_rdata[g])
    );
  end

  // --------------------------------------------------------------------------
  // Shared divider: crossing time = dividend / divisor, scaled per car type
  // --------------------------------------------------------------------------
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [15:0]           crossing;
  qentry_t               rd_entry;

  assign rd_entry = ram_rdata[gnt_side_r];

  always_comb begin
    unique case (rd_entry.car_type)
      CAR_SPORT: begin
        // 7*len / 10*speed
        div_dividend = (DIVIDEND_W'(length_r) << 3) - DIVIDEND_W'(length_r);
        div_divisor  = (DIVISOR_W'(speed_r) << 3) + (DIVISOR_W'(speed_r) << 1);
      end
      CAR_EMERGENCY: begin
        div_dividend = DIVIDEND_W'(length_r);
        div_divisor  = DIVISOR_W'(speed_r) << 1;
      end
      default: begin
        div_dividend = DIVIDEND_W'(length_r);
        div_divisor  = DIVISOR_W'(speed_r);
      end
    endcase
  end

  tqqa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // floor, minimum 1, saturate; a zero speed gives all ones -> 65535
  always_comb begin
    if (div_quo == '0) begin
      crossing = 16'd1;
    end else if (|div_quo[DIVIDEND_W-1:16]) begin
      crossing = 16'hFFFF;
    end else begin
      crossing = div_quo[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Side selection policy for a serve transfer
  // --------------------------------------------------------------------------
  logic        have [2];
  logic        pick_ok;
  logic        pick_side;
  logic        d_side;
  logic        o_side;
  logic [7:0]  pass_pol [2];
  logic        dir_pol;
  logic        sign_pol;
  logic [15:0] lfsr_pol;

  always_comb begin
    have[0]   = (cnt_r[0] != '0);
    have[1]   = (cnt_r[1] != '0);
    d_side    = flow_dir_r;
    o_side    = ~flow_dir_r;
    pass_pol  = passed_r;
    dir_pol   = flow_dir_r;
    sign_pol  = sign_dir_r;
    lfsr_pol  = lfsr_r;
    pick_ok   = 1'b0;
    pick_side = 1'b0;
    unique case (mode_r)
      MODE_QUOTA: begin
        if (have[d_side] && passed_r[d_side] < quota_r) begin
          pass_pol[d_side] = passed_r[d_side] + 8'd1;
          pick_ok          = 1'b1;
          pick_side        = d_side;
        end else begin
          pass_pol[d_side] = '0;
          dir_pol          = o_side;
          if (have[o_side] && passed_r[o_side] < quota_r) begin
            pass_pol[o_side] = passed_r[o_side] + 8'd1;
            pick_ok          = 1'b1;
            pick_side        = o_side;
          end else begin
            pass_pol[o_side] = '0;
            // only one side waiting: it goes regardless of quota
            if (have[0] && !have[1]) begin
              pass_pol[0] = 8'd1;
              pass_pol[1] = '0;
              dir_pol     = 1'b0;
              pick_ok     = 1'b1;
              pick_side   = 1'b0;
            end else if (have[1] && !have[0]) begin
              pass_pol[1] = 8'd1;
              pass_pol[0] = '0;
              dir_pol     = 1'b1;
              pick_ok     = 1'b1;
              pick_side   = 1'b1;
            end
          end
        end
      end
      MODE_SIGN: begin
        if (have[sign_dir_r]) begin
          pick_ok   = 1'b1;
          pick_side = sign_dir_r;
        end else if (have[~sign_dir_r]) begin
          pick_ok   = 1'b1;
          pick_side = ~sign_dir_r;
        end
        sign_pol = ~sign_dir_r;
      end
      MODE_RANDOM: begin
        if (have[0] && have[1]) begin
          // Galois step, the bit shifted out picks the side
          lfsr_pol  = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? LFSR_MASK : 16'h0000);
          pick_ok   = 1'b1;
          pick_side = lfsr_r[0];
        end else if (have[0]) begin
          pick_ok   = 1'b1;
          pick_side = 1'b0;
        end else if (have[1]) begin
          pick_ok   = 1'b1;
          pick_side = 1'b1;
        end
      end
      default: pick_ok = 1'b0;  // unused mode: no grant, no state change
    endcase
  end

  // --------------------------------------------------------------------------
  // Enqueue slot: (head + count) wrapped once
  // --------------------------------------------------------------------------
  logic          enq_full;
  logic [PW-1:0] enq_pos;

  always_comb begin
    enq_full = (cnt_r[in_data.side] == CW'(QUEUE_DEPTH));
    enq_pos  = PW'(head_r[in_data.side]) + PW'(cnt_r[in_data.side]);
    if (enq_pos >= PW'(QUEUE_DEPTH)) begin
      enq_pos = enq_pos - PW'(QUEUE_DEPTH);
    end
    ram_waddr          = enq_pos[AW-1:0];
    ram_wdata.car_id   = in_data.car_id;
    ram_wdata.car_type = in_data.car_type;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    passed_nxt    = passed_r;
    flow_dir_nxt  = flow_dir_r;
    sign_dir_nxt  = sign_dir_r;
    lfsr_nxt      = lfsr_r;
    gnt_side_nxt  = gnt_side_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we[0]     = 1'b0;
    ram_we[1]     = 1'b0;
    ram_re[0]     = 1'b0;
    ram_re[1]     = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.req_type == REQ_ENQUEUE) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            if (enq_full) begin
              out_data_nxt.status = ST_FULL;  // dropped
            end else begin
              out_data_nxt.status      = ST_ENQUEUED;
              ram_we[in_data.side]     = 1'b1;
              cnt_nxt[in_data.side]    = cnt_r[in_data.side] + CW'(1);
            end
          end else begin
            passed_nxt   = pass_pol;
            flow_dir_nxt = dir_pol;
            sign_dir_nxt = sign_pol;
            lfsr_nxt     = lfsr_pol;
            if (pick_ok) begin
              ram_re[pick_side]  = 1'b1;
              cnt_nxt[pick_side] = cnt_r[pick_side] - CW'(1);
              if (head_r[pick_side] == AW'(QUEUE_DEPTH - 1)) begin
                head_nxt[pick_side] = '0;
              end else begin
                head_nxt[pick_side] = head_r[pick_side] + AW'(1);
              end
              gnt_side_nxt = pick_side;
              state_nxt    = S_READ;
            end else begin
              out_valid_nxt       = 1'b1;
              out_data_nxt        = '0;
              out_data_nxt.status = ST_EMPTY;
            end
          end
        end
      end
      S_READ: begin
        div_start                 = 1'b1;
        out_data_nxt.status       = ST_GRANTED;
        out_data_nxt.granted_side = gnt_side_r;
        out_data_nxt.granted_id   = rd_entry.car_id;
        out_data_nxt.granted_type = rd_entry.car_type;
        state_nxt                 = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          out_data_nxt.crossing_time = crossing;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '{default: '0};
      head_r      <= '{default: '0};
      passed_r    <= '{default: '0};
      flow_dir_r  <= 1'b0;
      sign_dir_r  <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
      mode_r      <= FLOW_MODE_RST;
      quota_r     <= QUOTA_RST;
      length_r    <= LENGTH_RST;
      speed_r     <= SPEED_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      passed_r    <= passed_nxt;
      flow_dir_r  <= flow_dir_nxt;
      sign_dir_r  <= sign_dir_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      quota_r     <= quota_nxt;
      length_r    <= length_nxt;
      speed_r     <= speed_nxt;
    end
    gnt_side_r <= gnt_side_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_enq_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.req_type == REQ_ENQUEUE) |=> out_valid)
    else $error("enqueue transfer not answered next cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CW'(QUEUE_DEPTH)) && (cnt_r[1] <= CW'(QUEUE_DEPTH)))
    else $error("queue fill count beyond depth");

  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != 16'h0000)
    else $error("LFSR locked at zero");

  a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_GRANTED) |->
      (out_data.crossing_time == 16'd0 && out_data.granted_id == 16'd0))
    else $error("grant fields set without a grant");

  a_grant_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_GRANTED) |-> $past(div_done))
    else $error("grant issued without divider completion");

endmodule : two_queue_quota_arbiter_unit
`default_nettype wire

### rtl/tqqa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqqa_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tqqa_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tqqa_ram
`default_nettype wire

### rtl/tqqa_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqqa_div - iterative restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module tqqa_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [tqqa_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [tqqa_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                 done,
  output logic      [tqqa_pkg::DIVIDEND_W-1:0] quotient
);
  import tqqa_pkg::*;

  localparam int NB    = DIVIDEND_W;
  localparam int DB    = DIVISOR_W;
  localparam int CNT_W = $clog2(NB + 1);

  logic [DB-1:0]    rem_r, rem_nxt;
  logic [NB-1:0]    quo_r, quo_nxt;
  logic [DB-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  logic [DB:0] trial;
  logic [DB:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem_r, quo_r[NB-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};

    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(NB);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DB-1:0] : trial[DB-1:0];
      quo_nxt  = {quo_r[NB-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule : tqqa_div
`default_nettype wire

### tb/two_queue_quota_arbiter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_quota_arbiter_unit_tb - self-checking bench for the lane arbiter
// Drives enqueue and serve transfers under every side policy and a spread of
// register settings. A scoreboard keeps its own copy of both car queues and
// of the policy state, predicts each answer and checks it field by field.
// ----------------------------------------------------------------------------
module two_queue_quota_arbiter_unit_tb;
  import tqqa_pkg::*;

  localparam int QDEPTH         = 16;
  // Longest normal quiet spell is a sender gap under heavy idling plus one
  // divider run; the limit sits far above both.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;

  localparam logic [1:0] MODE_INVALID = 2'd3;
  localparam logic [1:0] CAR_NORMAL   = 2'd0;
  localparam logic [1:0] CAR_ALIAS    = 2'd3;  // decodes as normal
  localparam logic       SIDE_LEFT    = 1'b0;
  localparam logic       SIDE_RIGHT   = 1'b1;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of queues, policy state and registers.
  // --------------------------------------------------------------------------
  class lane_grant_model;
    qentry_t     lane_mem [2][QDEPTH];
    int unsigned head [2];
    int unsigned fill [2];
    int unsigned passed [2];
    bit          flow_dir;
    bit          sign_dir;
    logic [15:0] lfsr;
    logic [1:0]  mode;
    logic [7:0]  quota_r;
    logic [15:0] length_r;
    logic [15:0] speed_r;
    out_item_t   awaited [$];
    int          errors, answers, grants, fulls, empties;

    function new();
      for (int s = 0; s < 2; s++) begin
        head[s]   = 0;
        fill[s]   = 0;
        passed[s] = 0;
      end
      flow_dir = 1'b0;
      sign_dir = 1'b0;
      lfsr     = LFSR_SEED;
      mode     = FLOW_MODE_RST;
      quota_r  = QUOTA_RST;
      length_r = LENGTH_RST;
      speed_r  = SPEED_RST;
      errors   = 0;
      answers  = 0;
      grants   = 0;
      fulls    = 0;
      empties  = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FLOW_MODE:     mode     = val[1:0];
        REG_QUOTA:         quota_r  = val[7:0];
        REG_STREET_LENGTH: length_r = val;
        REG_CAR_SPEED:     speed_r  = val;
      endcase
    endfunction

    // length/speed scaled by 1, 7/10 or 1/2, floored, at least 1
    function logic [15:0] crossing_ticks(logic [1:0] kind);
      longint unsigned num, den, t;
      if (speed_r == 16'd0) return 16'hFFFF;
      num = length_r;
      den = speed_r;
      if (kind == CAR_SPORT) begin
        num = num * 7;
        den = den * 10;
      end else if (kind == CAR_EMERGENCY) begin
        den = den * 2;
      end
      t = num / den;
      if (t == 0) t = 1;
      if (t > 65535) t = 65535;
      return t[15:0];
    endfunction

    function int pick_quota();
      int d = flow_dir;
      int o = 1 - d;
      if (fill[d] > 0 && passed[d] < quota_r) begin
        passed[d]++;
        return d;
      end
      passed[d] = 0;
      flow_dir  = o[0];
      if (fill[o] > 0 && passed[o] < quota_r) begin
        passed[o]++;
        return o;
      end
      passed[o] = 0;
      // fall back to the only side with cars
      if (fill[0] > 0 && fill[1] == 0) begin
        passed[0] = 1;
        passed[1] = 0;
        flow_dir  = 1'b0;
        return 0;
      end
      if (fill[1] > 0 && fill[0] == 0) begin
        passed[1] = 1;
        passed[0] = 0;
        flow_dir  = 1'b1;
        return 1;
      end
      return -1;
    endfunction

    function int pick_sign();
      int s = sign_dir;
      int r = -1;
      if (fill[s] > 0) r = s;
      else if (fill[1 - s] > 0) r = 1 - s;
      sign_dir = ~sign_dir;
      return r;
    endfunction

    function int pick_random();
      bit coin;
      if (fill[0] > 0 && fill[1] > 0) begin
        coin = lfsr[0];
        lfsr = lfsr >> 1;
        if (coin) lfsr = lfsr ^ LFSR_MASK;
        return coin;
      end
      if (fill[0] > 0) return 0;
      if (fill[1] > 0) return 1;
      return -1;
    endfunction

    function out_item_t predict_answer(in_item_t it);
      out_item_t ans;
      int        s;
      int        sd;
      qentry_t   e;
      ans = '0;
      if (it.req_type == REQ_ENQUEUE) begin
        sd = it.side;
        if (fill[sd] >= QDEPTH) begin
          ans.status = ST_FULL;
        end else begin
          e.car_id   = it.car_id;
          e.car_type = it.car_type;
          lane_mem[sd][(head[sd] + fill[sd]) % QDEPTH] = e;
          fill[sd]++;
          ans.status = ST_ENQUEUED;
        end
        return ans;
      end
      case (mode)
        MODE_QUOTA:  s = pick_quota();
        MODE_SIGN:   s = pick_sign();
        MODE_RANDOM: s = pick_random();
        default:     s = -1;  // invalid policy: no grant, no state change
      endcase
      if (s < 0) begin
        ans.status = ST_EMPTY;
        return ans;
      end
      e       = lane_mem[s][head[s]];
      head[s] = (head[s] + 1) % QDEPTH;
      fill[s]--;
      ans.status        = ST_GRANTED;
      ans.granted_side  = (s == 1);
      ans.granted_id    = e.car_id;
      ans.granted_type  = e.car_type;
      ans.crossing_time = crossing_ticks(e.car_type);
      return ans;
    endfunction

    function void note_request(in_item_t it);
      awaited.push_back(predict_answer(it));
    endfunction

    task check_answer(out_item_t got);
      out_item_t want;
      answers++;
      case (got.status)
        ST_GRANTED: grants++;
        ST_FULL:    fulls++;
        ST_EMPTY:   empties++;
        default:    ;
      endcase
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("answer with no transfer pending, status %0d", got.status));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %h want %h", got.status, want.status));
      if (got.granted_side !== want.granted_side)
        report_mismatch($sformatf("granted_side got %h want %h",
                                  got.granted_side, want.granted_side));
      if (got.granted_id !== want.granted_id)
        report_mismatch($sformatf("granted_id got %h want %h",
                                  got.granted_id, want.granted_id));
      if (got.granted_type !== want.granted_type)
        report_mismatch($sformatf("granted_type got %h want %h",
                                  got.granted_type, want.granted_type));
      if (got.crossing_time !== want.crossing_time)
        report_mismatch($sformatf("crossing_time got %h want %h",
                                  got.crossing_time, want.crossing_time));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and signals
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lane_grant_model lane = new();
  int unsigned     quiet_cycles = 0;
  int              idle_pct     = 0;  // chance in a hundred of a sender gap cycle
  int              settings_run = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  two_queue_quota_arbiter_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Monitor: values seen here are the ones before the edge, so a transfer is
  // start & !busy as the DUT sees it. Results are one-cycle strobes and must
  // be taken on the edge that ends them.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) lane.note_request(in_data);
      if (out_valid) lane.check_answer(out_data);
    end
  end

  // Watchdog: quiet cycles are those with no transfer either way.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: nothing moved for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  function automatic in_item_t make_req(logic req, logic sd, logic [15:0] id,
                                        logic [1:0] kind);
    in_item_t it;
    it.req_type = req;
    it.side     = sd;
    it.car_id   = id;
    it.car_type = kind;
    return it;
  endfunction

  // start stays high after a transfer so back-to-back items need no second
  // assignment in the same step; it drops only for a gap or a pause.
  task automatic drive_request(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
  endtask

  // Block idle: nothing pending, then room for a grant still in the divider.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (lane.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    lane.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(logic [1:0] m, logic [7:0] q, logic [15:0] len,
                           logic [15:0] spd);
    write_register(REG_FLOW_MODE, CFG_DATA_W'(m));
    write_register(REG_QUOTA, CFG_DATA_W'(q));
    write_register(REG_STREET_LENGTH, len);
    write_register(REG_CAR_SPEED, spd);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // One setting, then a random mix of enqueues and serves. The enqueue bias
  // moves every 20 items so queues both drain dry and fill to the brim.
  task automatic run_phase(logic [1:0] m, logic [7:0] q, logic [15:0] len,
                           logic [15:0] spd, int n);
    in_item_t    it;
    logic [31:0] r;
    int          enq_bias;
    wait_idle();
    configure(m, q, len, spd);
    case (settings_run % 3)
      0:       idle_pct = 28;
      1:       idle_pct = 0;
      default: idle_pct = 87;
    endcase
    enq_bias = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) enq_bias = $urandom_range(25, 75);
      r           = $urandom;
      it.req_type = ($urandom_range(0, 99) < enq_bias) ? REQ_ENQUEUE : REQ_SERVE;
      it.side     = r[16];
      it.car_id   = r[15:0];
      it.car_type = r[18:17];
      drive_request(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_FLOW_MODE;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings (quota policy, quota 3, 100 / 10):
    // serve with both queues empty, fill the left queue to the brim, one
    // refused enqueue, id and type extremes, then a quota run that switches.
    idle_pct = 0;
    drive_request(make_req(REQ_SERVE, SIDE_LEFT, 16'h0000, CAR_NORMAL));
    drive_request(make_req(REQ_ENQUEUE, SIDE_LEFT, 16'h0000, CAR_NORMAL));
    drive_request(make_req(REQ_ENQUEUE, SIDE_LEFT, 16'hFFFF, CAR_ALIAS));
    drive_request(make_req(REQ_ENQUEUE, SIDE_LEFT, 16'h5555, CAR_SPORT));
    drive_request(make_req(REQ_ENQUEUE, SIDE_LEFT, 16'hAAAA, CAR_EMERGENCY));
    for (int k = 4; k < QDEPTH; k++)
      drive_request(make_req(REQ_ENQUEUE, SIDE_LEFT, 16'($urandom), 2'($urandom)));
    drive_request(make_req(REQ_ENQUEUE, SIDE_LEFT, 16'h1234, CAR_NORMAL));  // full
    drive_request(make_req(REQ_ENQUEUE, SIDE_RIGHT, 16'h8000, CAR_SPORT));
    drive_request(make_req(REQ_ENQUEUE, SIDE_RIGHT, 16'h7FFF, CAR_EMERGENCY));
    repeat (4) drive_request(make_req(REQ_SERVE, SIDE_RIGHT, 16'h0000, CAR_NORMAL));

    // Random part: every policy, quota 0 and 255, lane length and speed at
    // both ends, zero speed and the invalid policy code.
    run_phase(MODE_QUOTA,   8'd3,   16'd100,   16'd10,    200);
    run_phase(MODE_QUOTA,   8'd1,   16'hFFFF,  16'd1,     160);
    run_phase(MODE_QUOTA,   8'd255, 16'd1,     16'hFFFF,  160);
    run_phase(MODE_QUOTA,   8'd0,   16'd1000,  16'd7,     120);
    run_phase(MODE_SIGN,    8'd3,   16'd999,   16'd13,    200);
    run_phase(MODE_RANDOM,  8'd3,   16'd50000, 16'd3,     240);
    run_phase(MODE_RANDOM,  8'd2,   16'd12345, 16'd0,     120);
    run_phase(MODE_INVALID, 8'd5,   16'd100,   16'd10,     40);
    run_phase(MODE_SIGN,    8'd0,   16'd777,   16'hFFFF,  120);
    run_phase(MODE_QUOTA,   8'd2,   16'd40000, 16'd123,   200);

    wait_idle();
    $display("Run covered %0d answers: %0d grants, %0d refused enqueues, %0d empty serves.",
             lane.answers, lane.grants, lane.fulls, lane.empties);
    $display("%0d register settings over quota, sign, random and invalid policies.",
             settings_run);
    if (lane.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", lane.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/tqqa_pkg.sv
rtl/tqqa_ram.sv
rtl/tqqa_div.sv
rtl/two_queue_quota_arbiter_unit.sv
tb/two_queue_quota_arbiter_unit_tb.sv
